// ----- hdl/pmte_pkg.sv -----
// Shared types and constants of the per-module timestamp extender.
package pmte_pkg;

	localparam int unsigned IDX_W = 6;
	localparam int unsigned LOWER_W = 36;

	localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
	localparam logic [26:0] SYNC_GRACE_NS = 27'd100000000;
	localparam logic [3:0] DIRECT_WIRE_NS = 4'd14;
	localparam logic [15:0] MIN_PACKET_BYTES = 16'd12;
	localparam logic [IDX_W-1:0] DIRECT_FIRST_IDX = 6'd1;
	localparam logic [IDX_W-1:0] DIRECT_LAST_IDX = 6'd4;

	localparam logic [15:0] CABLE_OFFSET_RESET = 16'd0;
	localparam logic [3:0] SYNC_PERIOD_RESET = 4'd1;
	localparam logic [31:0] ROLLOVER_THRESHOLD_RESET = 32'd5000000;
	localparam logic [31:0] GAP_LIMIT_RESET = 32'd2000000000;
	localparam logic [34:0] MISS_LIMIT_RESET = 35'd1100000000;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_SHORT      = 2'd1,
		STATUS_BAD_MODULE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_CABLE_OFFSET       = 2'd0,
		REG_SYNC_PERIOD        = 2'd1,
		REG_ROLLOVER_THRESHOLD = 2'd2,
		REG_GAP_LIMIT          = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CMD_SHORT      = 2'd0,
		CMD_BAD_MODULE = 2'd1,
		CMD_HIT        = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [IDX_W-1:0]   idx;
		logic [LOWER_W-1:0] lower_ns;
		logic [31:0]        tsec;
	} cmd_t;

	typedef struct packed {
		logic [63:0]      timestamp_ns;
		status_t          status;
		logic [IDX_W-1:0] module_index;
		logic             first_in_module;
		logic             sync_seen;
		logic             large_gap;
		logic             missed_sync;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_SEC,
		ST_MUL_CNT,
		ST_SCALE,
		ST_SUM,
		ST_FINISH
	} back_state_t;

endpackage

// ----- hdl/pmte_front.sv -----
// Front end: accepts input words and classifies them into commands.
module pmte_front #(
	parameter int unsigned NUM_MODULES = 16
) (
	input  logic               push,
	input  logic               full,
	input  logic [15:0]        packet_bytes,
	input  logic [15:0]        module_number,
	input  logic [31:0]        lower_tick,
	input  logic [31:0]        time_packet_sec,
	output logic               cmd_push,
	output pmte_pkg::cmd_t     cmd
);

	localparam logic [15:0] MaxModule = 16'(NUM_MODULES);

	logic nothing;

	always_comb begin
		nothing = (packet_bytes == 16'd0) || (time_packet_sec == 32'd0);
		cmd_push = push && !full && !nothing;
		cmd.idx = pmte_pkg::IDX_W'(module_number - 16'd1);
		cmd.lower_ns = {lower_tick, 4'b0000};
		cmd.tsec = time_packet_sec;
		priority if (packet_bytes < pmte_pkg::MIN_PACKET_BYTES) begin
			cmd.kind = pmte_pkg::CMD_SHORT;
		end else if ((module_number == 16'd0) || (module_number > MaxModule)) begin
			cmd.kind = pmte_pkg::CMD_BAD_MODULE;
		end else begin
			cmd.kind = pmte_pkg::CMD_HIT;
		end
	end

endmodule

// ----- hdl/pmte_fifo.sv -----
// Small first-in first-out queue of command words between front and back end.
module pmte_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCount = CntW'(DEPTH);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full = (count_q == FullCount);
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/pmte_back.sv -----
// Back end: per-module stores, shared scaling multiplier and result register.
module pmte_back #(
	parameter int unsigned NUM_MODULES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                cmd_valid,
	input  pmte_pkg::cmd_t      cmd,
	output logic                cmd_pop,
	output pmte_pkg::result_t   res,
	output logic                res_empty,
	input  logic                res_pop
);

	localparam int unsigned IdxW = $clog2(NUM_MODULES);

	logic [15:0] cable_q;
	logic [3:0]  period_q;
	logic [31:0] thr_q;
	logic [31:0] gap_q;
	logic [34:0] miss_limit_q;

	logic [35:0]            lower_mem [NUM_MODULES];
	logic [31:0]            count_mem [NUM_MODULES];
	logic [NUM_MODULES-1:0] valid_q;
	logic [35:0]            lower_rd_q;
	logic [31:0]            count_rd_q;
	logic                   vld_rd_q;

	pmte_pkg::back_state_t state_q;
	pmte_pkg::back_state_t state_d;

	pmte_pkg::cmd_t cmd_q;
	logic           first_q;
	logic           sync_q;
	logic [31:0]    count_q;
	logic [63:0]    prod_q;
	logic [63:0]    syncns_q;
	logic [63:0]    base_q;
	logic [63:0]    ts_q;
	logic [63:0]    delta_q;
	logic           run_started_q;
	logic [63:0]    run_start_q;
	logic [63:0]    last_ts_q;
	logic           out_valid_q;
	pmte_pkg::result_t res_q;

	logic              out_free;
	logic              is_hit;
	logic              rd_en;
	logic              wr_en;
	logic              load_err;
	logic              load_hit;
	logic [IdxW-1:0]   rd_addr;
	logic [IdxW-1:0]   wr_addr;
	logic [31:0]       mul_a;
	logic [61:0]       mul_p;
	logic [35:0]       lower_last;
	logic [31:0]       count_old;
	logic              first_now;
	logic              sync_now;
	logic              direct;
	logic [63:0]       mag;
	logic [34:0]       miss_cfg;
	pmte_pkg::result_t res_d;

	always_comb begin
		miss_cfg = 35'(cfg_data[3:0]) * 35'(pmte_pkg::NS_PER_SEC)
			+ 35'(pmte_pkg::SYNC_GRACE_NS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cable_q <= pmte_pkg::CABLE_OFFSET_RESET;
			period_q <= pmte_pkg::SYNC_PERIOD_RESET;
			thr_q <= pmte_pkg::ROLLOVER_THRESHOLD_RESET;
			gap_q <= pmte_pkg::GAP_LIMIT_RESET;
			miss_limit_q <= pmte_pkg::MISS_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (pmte_pkg::cfg_reg_t'(cfg_index))
				pmte_pkg::REG_CABLE_OFFSET: begin
					cable_q <= cfg_data[15:0];
				end
				pmte_pkg::REG_SYNC_PERIOD: begin
					period_q <= cfg_data[3:0];
					miss_limit_q <= miss_cfg;
				end
				pmte_pkg::REG_ROLLOVER_THRESHOLD: begin
					thr_q <= cfg_data;
				end
				pmte_pkg::REG_GAP_LIMIT: begin
					gap_q <= cfg_data;
				end
			endcase
		end
	end

	assign out_free = !out_valid_q || res_pop;
	assign is_hit = (cmd.kind == pmte_pkg::CMD_HIT);
	assign rd_addr = cmd.idx[IdxW-1:0];
	assign wr_addr = cmd_q.idx[IdxW-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pmte_pkg::ST_IDLE: begin
				if (cmd_valid && is_hit) begin
					state_d = pmte_pkg::ST_MUL_SEC;
				end
			end
			pmte_pkg::ST_MUL_SEC: state_d = pmte_pkg::ST_MUL_CNT;
			pmte_pkg::ST_MUL_CNT: state_d = pmte_pkg::ST_SCALE;
			pmte_pkg::ST_SCALE: state_d = pmte_pkg::ST_SUM;
			pmte_pkg::ST_SUM: state_d = pmte_pkg::ST_FINISH;
			pmte_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = pmte_pkg::ST_IDLE;
				end
			end
			default: state_d = pmte_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en = 1'b0;
		wr_en = 1'b0;
		load_err = 1'b0;
		load_hit = 1'b0;
		cmd_pop = 1'b0;
		unique case (state_q)
			pmte_pkg::ST_IDLE: begin
				rd_en = cmd_valid && is_hit;
				load_err = cmd_valid && !is_hit && out_free;
				cmd_pop = rd_en || load_err;
			end
			pmte_pkg::ST_MUL_CNT: wr_en = 1'b1;
			pmte_pkg::ST_FINISH: load_hit = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pmte_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			lower_rd_q <= lower_mem[rd_addr];
			count_rd_q <= count_mem[rd_addr];
			vld_rd_q <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			lower_mem[wr_addr] <= cmd_q.lower_ns;
			count_mem[wr_addr] <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	assign mul_a = (state_q == pmte_pkg::ST_MUL_SEC) ? cmd_q.tsec : count_q;
	assign mul_p = mul_a * pmte_pkg::NS_PER_SEC;

	always_comb begin
		lower_last = vld_rd_q ? lower_rd_q : '0;
		count_old = vld_rd_q ? count_rd_q : '0;
		first_now = (lower_last == '0);
		sync_now = !first_now
			&& (({1'b0, cmd_q.lower_ns} + 37'(thr_q)) < {1'b0, lower_last});
		direct = (cmd_q.idx >= pmte_pkg::DIRECT_FIRST_IDX)
			&& (cmd_q.idx <= pmte_pkg::DIRECT_LAST_IDX);
		mag = delta_q[63] ? (64'd0 - delta_q) : delta_q;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pmte_pkg::ST_IDLE: begin
				if (rd_en) begin
					cmd_q <= cmd;
				end
			end
			pmte_pkg::ST_MUL_SEC: begin
				first_q <= first_now;
				sync_q <= sync_now;
				count_q <= count_old + 32'(sync_now);
				prod_q <= 64'(mul_p);
			end
			pmte_pkg::ST_MUL_CNT: begin
				prod_q <= 64'(mul_p);
			end
			pmte_pkg::ST_SCALE: begin
				syncns_q <= first_q ? 64'd0 : 64'(prod_q * period_q);
				base_q <= 64'(cmd_q.lower_ns) + run_start_q
					- ((direct && !first_q) ? 64'(pmte_pkg::DIRECT_WIRE_NS) : 64'd0);
			end
			pmte_pkg::ST_SUM: begin
				ts_q <= base_q + syncns_q;
				delta_q <= base_q + syncns_q - last_ts_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_started_q <= 1'b0;
			run_start_q <= '0;
			last_ts_q <= '0;
		end else begin
			if ((state_q == pmte_pkg::ST_MUL_CNT) && !run_started_q) begin
				run_started_q <= 1'b1;
				run_start_q <= prod_q - 64'(cmd_q.lower_ns) - 64'(cable_q);
				last_ts_q <= prod_q;
			end else if (load_hit && !first_q) begin
				last_ts_q <= ts_q;
			end
		end
	end

	always_comb begin
		res_d = '0;
		if (load_err) begin
			res_d.status = (cmd.kind == pmte_pkg::CMD_SHORT)
				? pmte_pkg::STATUS_SHORT : pmte_pkg::STATUS_BAD_MODULE;
		end else begin
			res_d.timestamp_ns = ts_q;
			res_d.status = pmte_pkg::STATUS_OK;
			res_d.module_index = cmd_q.idx;
			res_d.first_in_module = first_q;
			res_d.sync_seen = sync_q;
			res_d.large_gap = !first_q && (mag > 64'(gap_q));
			res_d.missed_sync = !first_q && ({1'b0, cmd_q.lower_ns} > 37'(miss_limit_q));
		end
	end

	always_ff @(posedge clk) begin
		if (load_err || load_hit) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_err || load_hit) begin
			out_valid_q <= 1'b1;
		end else if (res_pop) begin
			out_valid_q <= 1'b0;
		end
	end

	assign res = res_q;
	assign res_empty = !out_valid_q;

endmodule

// ----- hdl/per_module_timestamp_extender.sv -----
// Top level of the per-module timestamp extender.
//
// Hit words enter through push/full and are taken at an edge with push high and
// full low. Words with zero length or zero seconds are taken and dropped. Each
// other word yields one result word, shown on the result ports while empty is
// low and taken at an edge with pop high. Registers are written through cfg_we,
// cfg_index and cfg_data. The user must write them only while the block is
// idle; the block itself does not enforce this. A front end classifies words
// into a command queue of CMD_DEPTH entries. The back end runs a valid hit
// through store read, two passes through one shared 32 by 30 bit multiplier
// (seconds and sync count to nanoseconds), period scaling, a sum and the final
// compares, and takes no new command until the hit leaves. A short packet or
// bad module word goes from idle to the result register once that is free.
// Reset clears the run start, the last timestamp and the valid bits of the
// per-module stores, so no clearing pass is needed. If pop stays low the
// result register holds, the back end waits, the queue fills and full rises.
module per_module_timestamp_extender #(
	parameter int unsigned NUM_MODULES = 16,
	parameter int unsigned CMD_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [15:0] packet_bytes,
	input  logic [15:0] module_number,
	input  logic [31:0] lower_tick,
	input  logic [31:0] time_packet_sec,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] timestamp_ns,
	output logic [1:0]  status,
	output logic [5:0]  module_index,
	output logic        first_in_module,
	output logic        sync_seen,
	output logic        large_gap,
	output logic        missed_sync
);

	localparam int unsigned CmdW = $bits(pmte_pkg::cmd_t);

	logic              cmd_push;
	pmte_pkg::cmd_t    cmd_in;
	logic [CmdW-1:0]   cmd_head_bits;
	pmte_pkg::cmd_t    cmd_head;
	logic              cmd_empty;
	logic              cmd_pop;
	pmte_pkg::result_t res;

	pmte_front #(
		.NUM_MODULES(NUM_MODULES)
	) u_front (
		.push(push),
		.full(full),
		.packet_bytes(packet_bytes),
		.module_number(module_number),
		.lower_tick(lower_tick),
		.time_packet_sec(time_packet_sec),
		.cmd_push(cmd_push),
		.cmd(cmd_in)
	);

	pmte_fifo #(
		.WIDTH(CmdW),
		.DEPTH(CMD_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(cmd_push),
		.wdata(cmd_in),
		.full(full),
		.pop(cmd_pop),
		.rdata(cmd_head_bits),
		.empty(cmd_empty)
	);

	assign cmd_head = pmte_pkg::cmd_t'(cmd_head_bits);

	pmte_back #(
		.NUM_MODULES(NUM_MODULES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd_valid(!cmd_empty),
		.cmd(cmd_head),
		.cmd_pop(cmd_pop),
		.res(res),
		.res_empty(empty),
		.res_pop(pop)
	);

	assign timestamp_ns = res.timestamp_ns;
	assign status = res.status;
	assign module_index = res.module_index;
	assign first_in_module = res.first_in_module;
	assign sync_seen = res.sync_seen;
	assign large_gap = res.large_gap;
	assign missed_sync = res.missed_sync;

endmodule

// ----- tb/sv/per_module_timestamp_extender_tb.sv -----
// Self-checking testbench for the per-module timestamp extender.
`timescale 1ns / 100ps

module per_module_timestamp_extender_tb;

	localparam int MODULES = 16;
	localparam int LIMIT_CYCLES = 500000;
	localparam int SETTLE_CYCLES = 20;
	localparam logic [63:0] ONE_SEC_NS = 64'd1000000000;
	localparam logic [63:0] GRACE_NS = 64'd100000000;
	localparam logic [63:0] WIRE_NS = 64'd14;
	localparam logic [15:0] SHORT_BYTES = 16'd12;
	localparam logic [5:0] WIRE_FIRST = 6'd1;
	localparam logic [5:0] WIRE_LAST = 6'd4;
	localparam logic [31:0] BASE_SEC = 32'd1700000000;

	typedef struct {
		bit [15:0] bytes;
		bit [15:0] modnum;
		bit [31:0] tick;
		bit [31:0] tsec;
	} hit_word_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        push;
	logic        full;
	logic [15:0] packet_bytes;
	logic [15:0] module_number;
	logic [31:0] lower_tick;
	logic [31:0] time_packet_sec;
	logic        empty;
	logic        pop;
	logic [63:0] timestamp_ns;
	logic [1:0]  status;
	logic [5:0]  module_index;
	logic        first_in_module;
	logic        sync_seen;
	logic        large_gap;
	logic        missed_sync;

	// Register copies and extender state as the block should hold them.
	logic [15:0] cfg_cable;
	logic [3:0]  cfg_period;
	logic [31:0] cfg_thresh;
	logic [31:0] cfg_gap;
	bit          run_live;
	logic [63:0] run_start;
	logic [63:0] last_stamp;
	logic [35:0] prev_lower [0:MODULES-1];
	logic [31:0] rollovers [0:MODULES-1];

	hit_word_t          word_q[$];
	pmte_pkg::result_t  stamp_q[$];
	int        mismatches;
	int        cycles;

	hit_word_t cur_word;
	int        burst_left;
	int        idle_left;
	int        words_sent;
	bit        hold_drain;
	bit        took;
	int        stall_mode;
	int        stall_left;
	logic [12:0] stall_pat = 13'b1011001110101;

	bit [31:0] tick_walk [0:MODULES-1];
	bit [31:0] sec_now;

	per_module_timestamp_extender #(
		.NUM_MODULES(MODULES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.packet_bytes(packet_bytes),
		.module_number(module_number),
		.lower_tick(lower_tick),
		.time_packet_sec(time_packet_sec),
		.empty(empty),
		.pop(pop),
		.timestamp_ns(timestamp_ns),
		.status(status),
		.module_index(module_index),
		.first_in_module(first_in_module),
		.sync_seen(sync_seen),
		.large_gap(large_gap),
		.missed_sync(missed_sync)
	);

	always #10 clk = ~clk;

	function automatic bit extend_hit(input hit_word_t w, output pmte_pkg::result_t r);
		logic [63:0] lower;
		logic [63:0] stamp;
		logic [63:0] delta;
		logic [63:0] mag;
		logic [5:0]  m;
		r = '0;
		if (w.bytes == 0 || w.tsec == 0)
			return 1'b0;
		if (w.bytes < SHORT_BYTES) begin
			r.status = pmte_pkg::STATUS_SHORT;
			return 1'b1;
		end
		if (w.modnum == 0 || w.modnum > MODULES) begin
			r.status = pmte_pkg::STATUS_BAD_MODULE;
			return 1'b1;
		end
		m = 6'(w.modnum - 16'd1);
		lower = {28'd0, w.tick, 4'd0};
		if (!run_live) begin
			run_start = 64'(w.tsec) * ONE_SEC_NS - lower - 64'(cfg_cable);
			last_stamp = 64'(w.tsec) * ONE_SEC_NS;
			run_live = 1'b1;
		end
		r.status = pmte_pkg::STATUS_OK;
		r.module_index = m;
		if (prev_lower[m] == 0) begin
			prev_lower[m] = lower[35:0];
			r.timestamp_ns = lower + run_start;
			r.first_in_module = 1'b1;
			return 1'b1;
		end
		if (lower + 64'(cfg_thresh) < 64'(prev_lower[m])) begin
			rollovers[m] = rollovers[m] + 32'd1;
			r.sync_seen = 1'b1;
		end
		stamp = lower + run_start + 64'(rollovers[m]) * ONE_SEC_NS * 64'(cfg_period);
		if (m >= WIRE_FIRST && m <= WIRE_LAST)
			stamp = stamp - WIRE_NS;
		delta = stamp - last_stamp;
		mag = delta[63] ? (64'd0 - delta) : delta;
		r.large_gap = (mag > 64'(cfg_gap));
		r.missed_sync = (lower > 64'(cfg_period) * ONE_SEC_NS + GRACE_NS);
		last_stamp = stamp;
		prev_lower[m] = lower[35:0];
		r.timestamp_ns = stamp;
		return 1'b1;
	endfunction

	task automatic note_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
		mismatches++;
	endtask

	// Sender: bursts of words from the pending queue, random idle gaps between them.
	always @(negedge clk) begin
		if (!(push && !took)) begin
			if (hold_drain && stamp_q.size() == 0)
				hold_drain = 1'b0;
			if (arst_n && !hold_drain && burst_left > 0 && word_q.size() > 0) begin
				cur_word = word_q.pop_front();
				packet_bytes <= cur_word.bytes;
				module_number <= cur_word.modnum;
				lower_tick <= cur_word.tick;
				time_packet_sec <= cur_word.tsec;
				push <= 1'b1;
				burst_left--;
				words_sent++;
				if (words_sent % 300 == 0)
					hold_drain = 1'b1;
			end else begin
				push <= 1'b0;
				if (burst_left == 0) begin
					if (idle_left > 0) begin
						idle_left--;
					end else begin
						burst_left = ($urandom_range(0, 3) == 0) ?
							$urandom_range(50, 150) : $urandom_range(1, 24);
						idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
					end
				end
			end
		end
	end

	// Receiver stall pattern: free running, fixed rotation, light and heavy random stalls.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 4);
			stall_left = $urandom_range(50, 400);
		end else begin
			stall_left--;
		end
		stall_pat = {stall_pat[11:0], stall_pat[12]};
		case (stall_mode)
			0, 1: pop <= 1'b1;
			2: pop <= stall_pat[0];
			3: pop <= ($urandom_range(0, 3) != 0);
			default: pop <= ($urandom_range(0, 15) == 0);
		endcase
	end

	// Monitor: check the word taken this edge, then predict for a word accepted this edge.
	always @(posedge clk) begin
		pmte_pkg::result_t want;
		hit_word_t seen;
		pmte_pkg::result_t got_pred;
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end else if (arst_n) begin
			if (pop && !empty) begin
				if (stamp_q.size() == 0) begin
					note_mismatch("unexpected word, timestamp_ns", timestamp_ns, 64'd0);
				end else begin
					want = stamp_q.pop_front();
					if (timestamp_ns !== want.timestamp_ns)
						note_mismatch("timestamp_ns", timestamp_ns, want.timestamp_ns);
					if (status !== want.status)
						note_mismatch("status", 64'(status), 64'(want.status));
					if (module_index !== want.module_index)
						note_mismatch("module_index", 64'(module_index), 64'(want.module_index));
					if (first_in_module !== want.first_in_module)
						note_mismatch("first_in_module", 64'(first_in_module),
							64'(want.first_in_module));
					if (sync_seen !== want.sync_seen)
						note_mismatch("sync_seen", 64'(sync_seen), 64'(want.sync_seen));
					if (large_gap !== want.large_gap)
						note_mismatch("large_gap", 64'(large_gap), 64'(want.large_gap));
					if (missed_sync !== want.missed_sync)
						note_mismatch("missed_sync", 64'(missed_sync), 64'(want.missed_sync));
				end
			end
			took = push && !full;
			if (took) begin
				seen.bytes = packet_bytes;
				seen.modnum = module_number;
				seen.tick = lower_tick;
				seen.tsec = time_packet_sec;
				if (extend_hit(seen, got_pred))
					stamp_q.insert(stamp_q.size(), got_pred);
			end
		end
	end

	task automatic write_reg(input pmte_pkg::cfg_reg_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			pmte_pkg::REG_CABLE_OFFSET: cfg_cable = val[15:0];
			pmte_pkg::REG_SYNC_PERIOD: cfg_period = val[3:0];
			pmte_pkg::REG_ROLLOVER_THRESHOLD: cfg_thresh = val;
			default: cfg_gap = val;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_hit(input bit [15:0] bytes, input bit [15:0] modnum,
			input bit [31:0] tick, input bit [31:0] tsec);
		hit_word_t w;
		w.bytes = bytes;
		w.modnum = modnum;
		w.tick = tick;
		w.tsec = tsec;
		word_q.insert(word_q.size(), w);
	endtask

	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (word_q.size() != 0 || push || stamp_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly well-formed hits walking each module's tick counter, with rollbacks
	// and some noise, short packets and bad module numbers.
	task automatic queue_random(input int n);
		int made;
		int pick;
		int r;
		int m;
		hit_word_t w;
		made = 0;
		while (made < n) begin
			pick = $urandom_range(0, 99);
			w.bytes = 16'($urandom_range(12, 65535));
			w.modnum = 16'($urandom_range(1, MODULES));
			w.tick = $urandom;
			w.tsec = $urandom_range(1, 32'hFFFFFFFF);
			if (pick < 4) begin
				if ($urandom_range(0, 1))
					w.bytes = 0;
				else
					w.tsec = 0;
				w.modnum = 16'($urandom);
			end else if (pick < 9) begin
				w.bytes = 16'($urandom_range(1, 11));
				w.modnum = 16'($urandom);
				made++;
			end else if (pick < 14) begin
				w.modnum = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(MODULES + 1, 65535));
				made++;
			end else begin
				m = int'(w.modnum) - 1;
				r = $urandom_range(0, 99);
				if (r < 8)
					tick_walk[m] = $urandom_range(0, 2000);
				else if (r < 12)
					tick_walk[m] = $urandom;
				else if (r < 15)
					tick_walk[m] = 0;
				else
					tick_walk[m] = tick_walk[m] + $urandom_range(1, 20000000);
				w.tick = tick_walk[m];
				if ($urandom_range(0, 19) == 0)
					sec_now = sec_now + $urandom_range(1, 3);
				if ($urandom_range(0, 32) != 0)
					w.tsec = sec_now;
				made++;
			end
			word_q.insert(word_q.size(), w);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = pmte_pkg::REG_CABLE_OFFSET;
		cfg_data = '0;
		push = 1'b0;
		pop = 1'b0;
		packet_bytes = '0;
		module_number = '0;
		lower_tick = '0;
		time_packet_sec = '0;
		mismatches = 0;
		cycles = 0;
		burst_left = 0;
		idle_left = 0;
		words_sent = 0;
		hold_drain = 1'b0;
		took = 1'b0;
		stall_mode = 0;
		stall_left = 0;
		sec_now = BASE_SEC;
		cfg_cable = pmte_pkg::CABLE_OFFSET_RESET;
		cfg_period = pmte_pkg::SYNC_PERIOD_RESET;
		cfg_thresh = pmte_pkg::ROLLOVER_THRESHOLD_RESET;
		cfg_gap = pmte_pkg::GAP_LIMIT_RESET;
		run_live = 1'b0;
		run_start = '0;
		last_stamp = '0;
		for (int i = 0; i < MODULES; i++) begin
			prev_lower[i] = '0;
			rollovers[i] = '0;
			tick_walk[i] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(pmte_pkg::REG_CABLE_OFFSET, 32'h0000FFFF);
		write_reg(pmte_pkg::REG_SYNC_PERIOD, 32'd1);
		write_reg(pmte_pkg::REG_ROLLOVER_THRESHOLD, 32'd5000000);
		write_reg(pmte_pkg::REG_GAP_LIMIT, 32'd2000000000);
		@(posedge clk);
		#1;
		add_hit(16'd0, 16'd1, 32'd100, BASE_SEC);
		add_hit(16'd100, 16'd1, 32'd100, 32'd0);
		add_hit(16'd11, 16'd1, 32'd100, BASE_SEC);
		add_hit(16'd1, 16'hFFFF, 32'hFFFFFFFF, BASE_SEC);
		add_hit(16'd12, 16'd0, 32'd100, BASE_SEC);
		add_hit(16'd12, 16'd17, 32'd100, BASE_SEC);
		add_hit(16'hFFFF, 16'hFFFF, 32'd100, BASE_SEC);
		add_hit(16'hFFFF, 16'd1, 32'd0, 32'd1);
		add_hit(16'd12, 16'd1, 32'd0, BASE_SEC);
		add_hit(16'd64, 16'd1, 32'd1000, BASE_SEC);
		add_hit(16'd64, 16'd1, 32'd2000, BASE_SEC);
		add_hit(16'd64, 16'd2, 32'd5, BASE_SEC);
		add_hit(16'd64, 16'd2, 32'd10, BASE_SEC);
		add_hit(16'd64, 16'd5, 32'd7, BASE_SEC);
		add_hit(16'd64, 16'd5, 32'd9, BASE_SEC);
		add_hit(16'd64, 16'd6, 32'd3, BASE_SEC);
		add_hit(16'd64, 16'd6, 32'd4, BASE_SEC);
		add_hit(16'd64, 16'd16, 32'hFFFFFFFF, BASE_SEC);
		add_hit(16'd64, 16'd16, 32'd0, BASE_SEC);
		add_hit(16'd64, 16'd16, 32'hFFFFFFFF, BASE_SEC);
		add_hit(16'd64, 16'd16, 32'hFFFFFFF0, BASE_SEC);
		add_hit(16'd64, 16'd3, 32'd100, 32'hFFFFFFFF);
		add_hit(16'd64, 16'd3, 32'd200, 32'hFFFFFFFF);
		wait_drained();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					write_reg(pmte_pkg::REG_SYNC_PERIOD, 32'd15);
					write_reg(pmte_pkg::REG_ROLLOVER_THRESHOLD, 32'd0);
					write_reg(pmte_pkg::REG_GAP_LIMIT, 32'd0);
				end
				1: begin
					write_reg(pmte_pkg::REG_CABLE_OFFSET, 32'd0);
					write_reg(pmte_pkg::REG_SYNC_PERIOD, 32'd0);
					write_reg(pmte_pkg::REG_ROLLOVER_THRESHOLD, 32'hFFFFFFFF);
					write_reg(pmte_pkg::REG_GAP_LIMIT, 32'hFFFFFFFF);
				end
				2, 3: begin
					write_reg(pmte_pkg::REG_CABLE_OFFSET, $urandom_range(0, 65535));
					write_reg(pmte_pkg::REG_SYNC_PERIOD, $urandom_range(1, 15));
					write_reg(pmte_pkg::REG_ROLLOVER_THRESHOLD, ($urandom_range(0, 3) == 0) ?
						$urandom : $urandom_range(0, 50000000));
					write_reg(pmte_pkg::REG_GAP_LIMIT, ($urandom_range(0, 3) == 0) ?
						$urandom : $urandom_range(0, 1000000000));
				end
				default: begin
					write_reg(pmte_pkg::REG_CABLE_OFFSET, $urandom_range(0, 65535));
					write_reg(pmte_pkg::REG_SYNC_PERIOD, 32'd1);
					write_reg(pmte_pkg::REG_ROLLOVER_THRESHOLD, 32'd5000000);
					write_reg(pmte_pkg::REG_GAP_LIMIT, 32'd2000000000);
				end
			endcase
			@(posedge clk);
			#1;
			queue_random(250);
			wait_drained();
		end

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
